>>> rtl/ordered_list_insert_erase_defines.svh
// Assertion macros for the ordered list checker
`ifndef ORDERED_LIST_INSERT_ERASE_DEFINES_SVH
`define ORDERED_LIST_INSERT_ERASE_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define OLIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define OLIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/olie_pkg.sv
// Shared constants, codes and types of the ordered list block
`default_nettype none
package olie_pkg;

    localparam int CAPACITY = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int CNTO_W   = 6;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CMP_W-1:0]  CAP_EXT = CMP_W'(CAPACITY);
    localparam logic [CNTO_W-1:0] CAP_OUT = CAP_EXT[CNTO_W-1:0];

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT      = 3'd0,
        CMD_ERASE       = 3'd1,
        CMD_FIND        = 3'd2,
        CMD_APPEND      = 3'd3,
        CMD_REMOVE_LAST = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_t;

endpackage
`default_nettype wire

>>> rtl/olie_datapath.sv
// Datapath: command register, row of element cells, count and result register
`default_nettype none
module olie_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire olie_pkg::ctrl_t               ctrl,
    input  wire logic [olie_pkg::CMD_W-1:0]    cmd,
    input  wire logic [olie_pkg::POS_W-1:0]    pos,
    input  wire logic signed [olie_pkg::VAL_W-1:0] value,
    output logic [olie_pkg::STAT_W-1:0]        status,
    output logic                               found,
    output logic [olie_pkg::CNTO_W-1:0]        count_after
);

    logic [olie_pkg::CMD_W-1:0]  cmd_reg;
    logic [olie_pkg::POS_W-1:0]  pos_reg;
    logic [olie_pkg::VAL_W-1:0]  value_reg;
    logic [olie_pkg::VAL_W-1:0]  elem_reg [olie_pkg::CAPACITY];
    logic [olie_pkg::CNT_W-1:0]  count_reg;
    logic [olie_pkg::CNT_W-1:0]  count_next;
    logic [olie_pkg::STAT_W-1:0] status_reg;
    logic [olie_pkg::STAT_W-1:0] status_next;
    logic                        found_reg;
    logic                        found_next;
    logic [olie_pkg::CNTO_W-1:0] count_after_reg;
    logic [olie_pkg::CNTO_W-1:0] count_after_next;

    logic [olie_pkg::CMP_W-1:0]    cnt_ext;
    logic [olie_pkg::CMP_W-1:0]    pos_ext;
    logic [olie_pkg::CMP_W-1:0]    at;
    logic [olie_pkg::CMP_W-1:0]    cnt_next_ext;
    logic [olie_pkg::CAPACITY-1:0] match;
    logic                          full;
    logic                          empty;
    logic                          do_insert;
    logic                          do_erase;
    logic                          do_drop;

    assign cnt_ext = olie_pkg::CMP_W'(count_reg);
    assign pos_ext = olie_pkg::CMP_W'(pos_reg);
    assign full    = (count_reg == olie_pkg::CNT_W'(olie_pkg::CAPACITY));
    assign empty   = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= cmd;
            pos_reg   <= pos;
            value_reg <= value;
        end
    end

    always_comb
    begin
        do_insert   = 1'b0;
        do_erase    = 1'b0;
        do_drop     = 1'b0;
        at          = pos_ext;
        status_next = olie_pkg::ST_OK;
        found_next  = 1'b0;
        case (cmd_reg)
            olie_pkg::CMD_INSERT:
            begin
                if (full)
                    status_next = olie_pkg::ST_FULL;
                else if (pos_ext > cnt_ext)
                    status_next = olie_pkg::ST_RANGE;
                else
                    do_insert = 1'b1;
            end
            olie_pkg::CMD_ERASE:
            begin
                if (empty)
                    status_next = olie_pkg::ST_EMPTY;
                else if (pos_ext >= cnt_ext)
                    status_next = olie_pkg::ST_RANGE;
                else
                    do_erase = 1'b1;
            end
            olie_pkg::CMD_FIND:
            begin
                if (empty)
                    status_next = olie_pkg::ST_EMPTY;
                else
                    found_next = |match;
            end
            olie_pkg::CMD_APPEND:
            begin
                at = cnt_ext;
                if (full)
                    status_next = olie_pkg::ST_FULL;
                else
                    do_insert = 1'b1;
            end
            olie_pkg::CMD_REMOVE_LAST:
            begin
                if (empty)
                    status_next = olie_pkg::ST_EMPTY;
                else
                    do_drop = 1'b1;
            end
            default:
            begin
                status_next = olie_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        if (do_insert)
            count_next = count_reg + 1'b1;
        else if (do_erase || do_drop)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    assign cnt_next_ext     = olie_pkg::CMP_W'(count_next);
    assign count_after_next = cnt_next_ext[olie_pkg::CNTO_W-1:0];

    for (genvar g = 0; g < olie_pkg::CAPACITY; g++)
    begin : g_cell
        logic [olie_pkg::VAL_W-1:0] up_src;
        logic [olie_pkg::VAL_W-1:0] down_src;
        logic [olie_pkg::VAL_W-1:0] cell_next;

        if (g == 0)
        begin : g_first
            assign up_src = value_reg;
        end
        else
        begin : g_up
            assign up_src = elem_reg[g-1];
        end

        if (g == olie_pkg::CAPACITY - 1)
        begin : g_last
            assign down_src = elem_reg[g];
        end
        else
        begin : g_down
            assign down_src = elem_reg[g+1];
        end

        assign match[g] = (elem_reg[g] == value_reg) && (olie_pkg::CMP_W'(g) < cnt_ext);

        always_comb
        begin
            cell_next = elem_reg[g];
            if (do_insert)
            begin
                if (olie_pkg::CMP_W'(g) == at)
                    cell_next = value_reg;
                else if (olie_pkg::CMP_W'(g) > at)
                    cell_next = up_src;
            end
            else if (do_erase && (olie_pkg::CMP_W'(g) >= at))
            begin
                cell_next = down_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.commit)
                elem_reg[g] <= cell_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.commit)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            status_reg      <= status_next;
            found_reg       <= found_next;
            count_after_reg <= count_after_next;
        end
    end

    assign status      = status_reg;
    assign found       = found_reg;
    assign count_after = count_after_reg;

endmodule
`default_nettype wire

>>> rtl/olie_controller.sv
// Controller: command sequencing and output valid register
`default_nettype none
module olie_controller (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    output olie_pkg::ctrl_t ctrl
);

    olie_pkg::state_t state_reg;
    olie_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olie_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctrl.load      = 1'b0;
        ctrl.commit    = 1'b0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            olie_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = olie_pkg::S_EXEC;
                end
            end
            olie_pkg::S_EXEC:
            begin
                // hold until the result register is free
                if (out_free)
                begin
                    ctrl.commit    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = olie_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = olie_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> rtl/ordered_list_insert_erase.sv
// Top level of the ordered list block: insert, erase, find, append, remove last
// The result register is loaded in the execute step that follows capture of an accepted
// input transaction; no new transaction is taken until that step is done (capture, then
// execute, in which the cell row shifts or matches all positions in parallel).
// Execute waits while an earlier result is still stalled in the output register.
// Reset (rst_n, asynchronous, active low) empties the list; stored values stay undefined.
`default_nettype none
module ordered_list_insert_erase (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [olie_pkg::CMD_W-1:0]        cmd,
    input  wire logic [olie_pkg::POS_W-1:0]        pos,
    input  wire logic signed [olie_pkg::VAL_W-1:0] value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [olie_pkg::STAT_W-1:0]            status,
    output logic                                   found,
    output logic [olie_pkg::CNTO_W-1:0]            count_after
);

    olie_pkg::ctrl_t ctrl;

    olie_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    olie_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cmd         (cmd),
        .pos         (pos),
        .value       (value),
        .status      (status),
        .found       (found),
        .count_after (count_after)
    );

endmodule
`default_nettype wire

>>> rtl/olie_checker.sv
// Port-level checker for the ordered list block and its bind
`default_nettype none
`include "ordered_list_insert_erase_defines.svh"
module olie_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic [olie_pkg::CMD_W-1:0]        cmd,
    input wire logic [olie_pkg::POS_W-1:0]        pos,
    input wire logic signed [olie_pkg::VAL_W-1:0] value,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [olie_pkg::STAT_W-1:0]       status,
    input wire logic                              found,
    input wire logic [olie_pkg::CNTO_W-1:0]       count_after
);

    `OLIE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `OLIE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second transaction taken during execute")
    `OLIE_ASSERT(a_found_ok, out_valid && found |-> status == olie_pkg::ST_OK, "found with error status")
    `OLIE_ASSERT(a_full_count, out_valid && status == olie_pkg::ST_FULL |-> count_after == olie_pkg::CAP_OUT, "full status with wrong count")
    `OLIE_ASSERT(a_empty_count, out_valid && status == olie_pkg::ST_EMPTY |-> count_after == '0, "empty status with nonzero count")

endmodule

bind ordered_list_insert_erase olie_checker u_olie_checker (.*);
`default_nettype wire
